@@ design/csk_pkg.sv @@
// types, constants and crc functions shared by the seed-to-key pipeline
package csk_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte [5:0] t_buf;
    typedef t_byte [6:0] t_crcs;

    localparam int NUM_CRC = 7;
    localparam t_byte CRC_POLY = 8'h1D;
    localparam t_byte CRC_INIT = 8'hFF;
    localparam logic [15:0] SECRET_RESET = 16'h1234;
    localparam logic [2:0] KEY_LENGTH = 3'd4;

    function automatic t_byte crc_update(input t_byte acc_in, input t_byte data);
        t_byte acc;
        acc = acc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (acc[7]) begin
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    function automatic t_byte crc_six(input t_buf buf_in);
        t_byte acc;
        acc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            acc = crc_update(acc, buf_in[i]);
        end
        return ~acc;
    endfunction

endpackage

@@ design/csk_stage.sv @@
// one pipeline stage: computes one chained crc and registers it with the beat
module csk_stage #(
    parameter int SLOT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_valid,
    input  logic [31:0]       i_seed,
    input  logic [15:0]       i_secret,
    input  csk_pkg::t_crcs    i_crcs,
    output logic              o_valid,
    output logic [31:0]       o_seed,
    output csk_pkg::t_crcs    o_crcs
);

    logic           r_valid;
    logic [31:0]    r_seed;
    csk_pkg::t_crcs r_crcs;
    csk_pkg::t_buf  w_base;
    csk_pkg::t_buf  w_buf;
    csk_pkg::t_crcs n_crcs;

    always_comb begin
        w_base[0] = i_seed[31:24];
        w_base[1] = i_seed[23:16];
        w_base[2] = i_seed[15:8];
        w_base[3] = i_seed[7:0];
        w_base[4] = i_secret[15:8];
        w_base[5] = i_secret[7:0];
        // previous crc replaces byte SLOT-1
        for (int i = 0; i < 6; i++) begin
            w_buf[i] = (i == SLOT - 1) ? i_crcs[i] : w_base[i];
        end
        n_crcs       = i_crcs;
        n_crcs[SLOT] = csk_pkg::crc_six(w_buf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seed <= i_seed;
            r_crcs <= n_crcs;
        end
    end

    assign o_valid = r_valid;
    assign o_seed  = r_seed;
    assign o_crcs  = r_crcs;

endmodule

@@ design/crc8_chained_seed_key.sv @@
// top level of the chained crc-8 seed-to-key pipeline
//
// input channel: i_valid / o_stall carry one 32-bit seed per beat in i_seed_word,
// first seed byte in bits 31..24. a beat is taken when i_valid is high and
// o_stall is low.
// output channel: o_valid / i_stall carry o_key_word (first key byte in bits
// 31..24) and o_key_length, which is always 4.
// configuration: i_wr_en with i_wr_data loads the 16-bit secret; write it only
// while no beat is in flight.
// pipeline: one register stage per chained crc, seven stages in all.
// throughput: one seed per cycle while o_stall is low; every stage holds one beat.
// reset (i_rst_n low at a clock edge) empties the pipeline and sets the
// secret to 0x1234.
// when the receiver stalls, the last stage holds its key and earlier stages
// keep advancing into empty slots; o_stall rises only once all seven are full.
module crc8_chained_seed_key (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seed_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_key_word,
    output logic [2:0]  o_key_length,
    input  logic        i_wr_en,
    input  logic [15:0] i_wr_data
);

    localparam int NS = csk_pkg::NUM_CRC;

    logic [15:0]    r_secret;
    logic [NS-1:0]  w_valid;
    logic [NS-1:0]  w_ready;
    logic [31:0]    w_seed [NS];
    csk_pkg::t_crcs w_crcs [NS];
    csk_pkg::t_crcs w_last;
    logic           w_tail_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret <= csk_pkg::SECRET_RESET;
        end else if (i_wr_en) begin
            r_secret <= i_wr_data;
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_ready[NS-1] = !w_valid[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ready[k] = !w_valid[k] || w_ready[k+1];
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_first
            csk_stage #(.SLOT(k)) u_stage (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_load   (w_ready[k]),
                .i_valid  (i_valid),
                .i_seed   (i_seed_word),
                .i_secret (r_secret),
                .i_crcs   ('0),
                .o_valid  (w_valid[k]),
                .o_seed   (w_seed[k]),
                .o_crcs   (w_crcs[k])
            );
        end else begin : g_next
            csk_stage #(.SLOT(k)) u_stage (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_load   (w_ready[k]),
                .i_valid  (w_valid[k-1]),
                .i_seed   (w_seed[k-1]),
                .i_secret (r_secret),
                .i_crcs   (w_crcs[k-1]),
                .o_valid  (w_valid[k]),
                .o_seed   (w_seed[k]),
                .o_crcs   (w_crcs[k])
            );
        end
    end

    assign w_last      = w_crcs[NS-1];
    assign w_tail_zero = (w_last[3] == '0) && (w_last[4] == '0) &&
                         (w_last[5] == '0) && (w_last[6] == '0);

    assign o_stall      = !w_ready[0];
    assign o_valid      = w_valid[NS-1];
    assign o_key_word   = w_tail_zero ? {w_last[1], w_last[2], w_last[3], w_last[4]}
                                      : {w_last[3], w_last[4], w_last[5], w_last[6]};
    assign o_key_length = csk_pkg::KEY_LENGTH;

endmodule

@@ tb/sv/testbench.sv @@
// testbench for crc8_chained_seed_key: random and directed seeds checked against a crc-8 key predictor

class key_scoreboard;
    logic [31:0] key_fifo[$];
    int errors = 0;

    function csk_pkg::t_byte crc8_msb(input logic [47:0] data);
        csk_pkg::t_byte acc;
        logic fb;
        acc = 8'hFF;
        for (int i = 47; i >= 0; i--) begin
            fb = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? 8'h1D : 8'h00);
        end
        return ~acc;
    endfunction

    function csk_pkg::t_crcs crc_chain(input logic [31:0] seed, input logic [15:0] secret);
        csk_pkg::t_crcs c;
        logic [47:0] base;
        logic [47:0] work;
        base = {seed, secret};
        c[0] = crc8_msb(base);
        for (int k = 1; k < 7; k++) begin
            work = base;
            work[47 - 8 * (k - 1) -: 8] = c[k - 1];
            c[k] = crc8_msb(work);
        end
        return c;
    endfunction

    function logic [31:0] key_for(input logic [31:0] seed, input logic [15:0] secret);
        csk_pkg::t_crcs c;
        c = crc_chain(seed, secret);
        if (c[3] == 8'h00 && c[4] == 8'h00 && c[5] == 8'h00 && c[6] == 8'h00) begin
            return {c[1], c[2], c[3], c[4]};
        end
        return {c[3], c[4], c[5], c[6]};
    endfunction

    function void note_seed(input logic [31:0] seed, input logic [15:0] secret);
        key_fifo.push_back(key_for(seed, secret));
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_key(input logic [31:0] key, input logic [2:0] len);
        logic [31:0] want;
        if (key_fifo.size() == 0) begin
            report($sformatf("key %08h with no seed waiting", key));
            return;
        end
        want = key_fifo.pop_front();
        if (key !== want) begin
            report($sformatf("key %08h, expected %08h", key, want));
        end
        if (len !== csk_pkg::KEY_LENGTH) begin
            report($sformatf("key length %0d, expected %0d", len, csk_pkg::KEY_LENGTH));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_seed_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_key_word;
    logic [2:0]  o_key_length;
    logic        i_wr_en = 1'b0;
    logic [15:0] i_wr_data = '0;

    key_scoreboard sb = new;
    logic [15:0] secret_now = csk_pkg::SECRET_RESET;
    logic        idling = 1'b1;
    int          rx_count = 0;

    logic [31:0] directed_seeds [10] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
        32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0123_4567, 32'hFEDC_BA98
    };

    crc8_chained_seed_key u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_seed_word  (i_seed_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_key_word   (o_key_word),
        .o_key_length (o_key_length),
        .i_wr_en      (i_wr_en),
        .i_wr_data    (i_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (rx_count > 0) begin
            rx_count = rx_count - 1;
        end else if (idling && $urandom_range(0, 2) == 0) begin
            i_stall <= 1'b1;
            rx_count = $urandom_range(0, 12);
        end else begin
            i_stall <= 1'b0;
            rx_count = $urandom_range(0, 30);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_key(o_key_word, o_key_length);
        end
    end

    function automatic logic [31:0] tail_of(input logic [47:0] data);
        csk_pkg::t_crcs c;
        c = sb.crc_chain(data[47:16], data[15:0]);
        return {c[3], c[4], c[5], c[6]};
    endfunction

    // crcs are affine in the buffer bits, so solve for a buffer whose last four crcs are zero
    function automatic logic [47:0] zero_tail_buffer(input logic [47:0] start);
        logic [48:0] rows [32];
        logic [48:0] tmp;
        logic [31:0] t0;
        logic [31:0] tj;
        logic [47:0] sol;
        int pivcol [32];
        int nr;
        int p;
        t0 = tail_of(start);
        for (int r = 0; r < 32; r++) begin
            rows[r] = '0;
            rows[r][48] = t0[r];
        end
        for (int j = 0; j < 48; j++) begin
            tj = tail_of(start ^ (48'd1 << j)) ^ t0;
            for (int r = 0; r < 32; r++) begin
                rows[r][j] = tj[r];
            end
        end
        nr = 0;
        for (int j = 0; j < 48; j++) begin
            if (nr < 32) begin
                p = -1;
                for (int i = nr; i < 32; i++) begin
                    if (p < 0 && rows[i][j]) begin
                        p = i;
                    end
                end
                if (p >= 0) begin
                    tmp = rows[p];
                    rows[p] = rows[nr];
                    rows[nr] = tmp;
                    for (int i = 0; i < 32; i++) begin
                        if (i != nr && rows[i][j]) begin
                            rows[i] = rows[i] ^ rows[nr];
                        end
                    end
                    pivcol[nr] = j;
                    nr++;
                end
            end
        end
        sol = start;
        for (int i = 0; i < nr; i++) begin
            if (rows[i][48]) begin
                sol[pivcol[i]] = ~sol[pivcol[i]];
            end
        end
        return sol;
    endfunction

    function automatic logic [31:0] random_seed();
        int mode;
        int pos;
        mode = $urandom_range(0, 9);
        pos = $urandom_range(0, 31);
        case (mode)
            0: begin
                return $urandom_range(0, 1) ? (32'd1 << pos) : ~(32'd1 << pos);
            end
            1: begin
                return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_seed(input logic [31:0] seed);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_seed_word <= seed;
        do @(posedge i_clk); while (o_stall);
        sb.note_seed(seed, secret_now);
    endtask

    task automatic load_secret(input logic [15:0] value);
        i_wr_en <= 1'b1;
        i_wr_data <= value;
        @(posedge i_clk);
        i_wr_en <= 1'b0;
        secret_now = value;
    endtask

    task automatic wait_keys_done();
        i_valid <= 1'b0;
        while (sb.key_fifo.size() != 0) @(posedge i_clk);
    endtask

    task automatic zero_tail_case();
        logic [47:0] zt;
        int tries;
        tries = 0;
        do begin
            zt = zero_tail_buffer({32'($urandom), 16'($urandom_range(0, 65535))});
            tries++;
        end while (tail_of(zt) != 32'd0 && tries < 8);
        load_secret(zt[15:0]);
        send_seed(zt[47:16]);
        send_seed(zt[47:16] ^ 32'd1);
        wait_keys_done();
    endtask

    initial begin
        int count;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset secret, extreme secrets, zero tail
        foreach (directed_seeds[i]) begin
            send_seed(directed_seeds[i]);
        end
        wait_keys_done();
        load_secret(16'h0000);
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        wait_keys_done();
        load_secret(16'hFFFF);
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        wait_keys_done();
        zero_tail_case();
        zero_tail_case();

        // random phases, last one without idling
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                idling <= 1'b0;
            end
            case (ph)
                0: load_secret(16'h0000);
                1: load_secret(16'hFFFF);
                2: load_secret(16'h8001);
                default: load_secret(16'($urandom_range(0, 65535)));
            endcase
            count = $urandom_range(120, 150);
            repeat (count) begin
                send_seed(random_seed());
            end
            wait_keys_done();
        end

        repeat (10) @(posedge i_clk);
        if (sb.key_fifo.size() != 0) begin
            sb.report($sformatf("%0d keys never arrived", sb.key_fifo.size()));
        end
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
